### design/filtered_proportional_controller_macros.svh
// Assertion macros shared by the controller RTL files.
`ifndef FILTERED_PROPORTIONAL_CONTROLLER_MACROS_SVH
`define FILTERED_PROPORTIONAL_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fpc_pkg.sv
// Package: constants, codes and control types of the filtered proportional controller.
package fpc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int TICK_BITS  = 16;
    localparam int GAIN_BITS  = 8;
    localparam int DRIVE_BITS = 8;
    localparam int ADDR_BITS  = 5;
    localparam int APB_BITS   = 32;

    localparam int DRIVE_MAX        = 255;
    localparam int GAIN_RESET       = 3;
    localparam int REF_LOW_RESET    = 450;
    localparam int REF_HIGH_RESET   = 550;
    localparam int PERIOD_RESET     = 5000;
    // Default alpha is 0.05 in percent units, rounded to the fraction width.
    localparam int ALPHA_PERCENT    = 5;

    typedef enum logic [2:0] {
        REG_GAIN     = 3'd0,
        REG_REF_LOW  = 3'd1,
        REG_REF_HIGH = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_ALPHA    = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_SUM,
        ST_DIFF,
        ST_MUL_GAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mul_old;
        logic sum;
        logic diff;
        logic mul_gain;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

### design/filtered_proportional_controller.sv
// Top level: configuration registers, sequencer and datapath of the filtered P controller.
//
// One sample item per control tick comes in on the s_ side; one result item per sample
// goes out on the m_ side. On each item the tick counter advances and, on reaching
// toggle_period, clears and flips the setpoint between ref_low and ref_high. The sample
// held from the previous item is run through a first-order low-pass filter
// (weight filter_alpha in Q1.FRAC_BITS, values above one act as one, truncating), the
// error setpoint minus filtered value is scaled by gain, truncated and clamped to
// 0..255; m_tuser reports which limit was hit (0 none, 1 high, 2 low). The result is
// loaded into the output register after the single multiplier has been used in turn
// for alpha*sample (at the accept edge), (1-alpha)*filter and gain*error, with the
// filter sum and the error subtraction between; a final step loads the result. An
// item holds the block from the idle cycle in which it is accepted until that final
// load, and while a waiting result sees m_tready low the final load is held back.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register does not stop the next item from being accepted, only its final load
// waits for m_tready. Configuration must go through the APB port only while no item
// is in work; the block itself does not enforce this. Registers sit at byte address
// 4*index: gain, ref_low, ref_high, toggle_period, filter_alpha.
module filtered_proportional_controller
    import fpc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream, tdata: sample
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // master stream, tdata: drive_level, filtered_level, setpoint
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((DRIVE_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // master stream, tuser: clamp_status
    output logic [1:0]            m_tuser,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [APB_BITS-1:0]   pwdata,
    output logic [APB_BITS-1:0]   prdata,
    output logic                  pready
);

    localparam int AW = FRAC_BITS + 1;
    // 0.05 in Q1.FRAC_BITS, rounded
    localparam int ALPHA_RESET = ((1 << FRAC_BITS) * ALPHA_PERCENT + 50) / 100;

    logic [GAIN_BITS-1:0]   gain_reg;
    logic [SAMPLE_BITS-1:0] ref_low_reg;
    logic [SAMPLE_BITS-1:0] ref_high_reg;
    logic [TICK_BITS-1:0]   period_reg;
    logic [AW-1:0]          alpha_reg;

    reg_index_t             reg_idx;
    logic                   wr_en;

    dp_cmd_t                cmd;
    dp_status_t             status;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_BITS'(GAIN_RESET);
            ref_low_reg  <= SAMPLE_BITS'(REF_LOW_RESET);
            ref_high_reg <= SAMPLE_BITS'(REF_HIGH_RESET);
            period_reg   <= TICK_BITS'(PERIOD_RESET);
            alpha_reg    <= AW'(ALPHA_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAIN:     gain_reg     <= pwdata[GAIN_BITS-1:0];
                REG_REF_LOW:  ref_low_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_REF_HIGH: ref_high_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_PERIOD:   period_reg   <= pwdata[TICK_BITS-1:0];
                REG_ALPHA:    alpha_reg    <= pwdata[AW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN:     prdata = APB_BITS'(gain_reg);
            REG_REF_LOW:  prdata = APB_BITS'(ref_low_reg);
            REG_REF_HIGH: prdata = APB_BITS'(ref_high_reg);
            REG_PERIOD:   prdata = APB_BITS'(period_reg);
            REG_ALPHA:    prdata = APB_BITS'(alpha_reg);
            default:      prdata = '0;
        endcase
    end

    fpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpc_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (s_tdata[SAMPLE_BITS-1:0]),
        .gain          (gain_reg),
        .ref_low       (ref_low_reg),
        .ref_high      (ref_high_reg),
        .toggle_period (period_reg),
        .filter_alpha  (alpha_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

### design/fpc_ctrl.sv
// Sequencer for the controller datapath: one item through the shared multiplier.
module fpc_ctrl
    import fpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "filtered_proportional_controller_macros.svh"

    `FPC_ASSERT_NEXT(a_accept_starts_filter, s_tvalid && s_tready, state_reg == ST_MUL_OLD, "accepted item did not start the filter step")
    `FPC_ASSERT_NOW(a_single_command, 1'b1, $onehot0(cmd), "more than one datapath command")
    `FPC_ASSERT_NEXT(a_finish_returns_idle, cmd.finish, s_tready, "block not ready after result load")

endmodule

### design/fpc_datapath.sv
// Datapath: tick counter, low-pass filter, proportional law, clamp and output register.
module fpc_datapath
    import fpc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [GAIN_BITS-1:0]   gain,
    input  logic [SAMPLE_BITS-1:0] ref_low,
    input  logic [SAMPLE_BITS-1:0] ref_high,
    input  logic [TICK_BITS-1:0]   toggle_period,
    input  logic [FRAC_BITS:0]     filter_alpha,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((DRIVE_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]             m_tuser
);

    localparam int FW  = SAMPLE_BITS + FRAC_BITS;
    localparam int AW  = FRAC_BITS + 1;
    localparam int PW  = AW + FW;
    localparam int DW  = DRIVE_BITS + 2 * SAMPLE_BITS;
    localparam int TDW = ((DW + 7) / 8) * 8;

    localparam logic [AW-1:0] ONE_FX    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] LIMIT_FX  = PW'(DRIVE_MAX) << FRAC_BITS;

    // controller state
    logic [TICK_BITS-1:0]   tick_reg;
    logic                   sel_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [FW-1:0]          filt_reg;

    // working registers
    logic [PW-1:0]          prod_reg;
    logic [FW-1:0]          acc_reg;
    logic [FW-1:0]          mag_reg;
    logic                   neg_reg;

    // output register
    logic                   out_valid_reg;
    logic [DRIVE_BITS-1:0]  drive_out_reg;
    logic [SAMPLE_BITS-1:0] filt_out_reg;
    logic [SAMPLE_BITS-1:0] sp_out_reg;
    clamp_t                 clamp_out_reg;

    logic [TICK_BITS-1:0]   tick_inc;
    logic [AW-1:0]          alpha_sat;
    logic [AW-1:0]          mul_a;
    logic [FW-1:0]          mul_b;
    logic [PW-1:0]          mul_p;
    logic [SAMPLE_BITS-1:0] ref_sel;
    logic [FW-1:0]          ref_fx;
    logic [DRIVE_BITS-1:0]  drive_next;
    clamp_t                 clamp_next;

    assign tick_inc  = tick_reg + 1'b1;
    assign alpha_sat = (filter_alpha > ONE_FX) ? ONE_FX : filter_alpha;
    assign ref_sel   = sel_reg ? ref_high : ref_low;
    assign ref_fx    = {ref_sel, {FRAC_BITS{1'b0}}};

    // one shared multiplier, operands picked by the step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.accept)
        begin
            mul_a = alpha_sat;
            mul_b = FW'(prev_reg);
        end
        else if (cmd.mul_old)
        begin
            mul_a = ONE_FX - alpha_sat;
            mul_b = filt_reg;
        end
        else if (cmd.mul_gain)
        begin
            mul_a = AW'(gain);
            mul_b = mag_reg;
        end
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // clamp: any negative nonzero product is low, strictly above max is high
    always_comb
    begin
        if (neg_reg && (prod_reg != '0))
        begin
            drive_next = '0;
            clamp_next = CLAMP_LOW;
        end
        else if (prod_reg > LIMIT_FX)
        begin
            drive_next = DRIVE_BITS'(DRIVE_MAX);
            clamp_next = CLAMP_HIGH;
        end
        else
        begin
            drive_next = prod_reg[FRAC_BITS +: DRIVE_BITS];
            clamp_next = CLAMP_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            sel_reg  <= 1'b0;
            prev_reg <= '0;
            filt_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (tick_inc >= toggle_period)
                begin
                    tick_reg <= '0;
                    sel_reg  <= ~sel_reg;
                end
                else
                begin
                    tick_reg <= tick_inc;
                end
                // old sample goes into the multiplier this same edge
                prev_reg <= sample;
            end
            if (cmd.sum)
            begin
                filt_reg <= acc_reg + prod_reg[FRAC_BITS +: FW];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.mul_old || cmd.mul_gain)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_old)
        begin
            acc_reg <= prod_reg[FW-1:0];
        end
        if (cmd.diff)
        begin
            if (filt_reg > ref_fx)
            begin
                neg_reg <= 1'b1;
                mag_reg <= filt_reg - ref_fx;
            end
            else
            begin
                neg_reg <= 1'b0;
                mag_reg <= ref_fx - filt_reg;
            end
        end
        if (cmd.finish)
        begin
            drive_out_reg <= drive_next;
            clamp_out_reg <= clamp_next;
            filt_out_reg  <= filt_reg[FRAC_BITS +: SAMPLE_BITS];
            sp_out_reg    <= ref_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = TDW'({sp_out_reg, filt_out_reg, drive_out_reg});
    assign m_tuser         = clamp_out_reg;

`include "filtered_proportional_controller_macros.svh"

    `FPC_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, out_valid_reg, "result load lost")
    `FPC_ASSERT_NOW(a_high_clamp_value, out_valid_reg && (clamp_out_reg == CLAMP_HIGH), drive_out_reg == DRIVE_BITS'(DRIVE_MAX), "high clamp without full drive")
    `FPC_ASSERT_NOW(a_low_clamp_value, out_valid_reg && (clamp_out_reg == CLAMP_LOW), drive_out_reg == '0, "low clamp with nonzero drive")

endmodule
